### rtl/bb3_pkg.sv
package bb3_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Push and pop strobes for the dual-push queue.
	// push1 writes the slot behind push0 and is only raised together with it.
	typedef struct packed {
		logic push0;
		logic push1;
		logic pop;
	} fifo_ctl_t;

endpackage

### rtl/binomial_blur_3x3_unit.sv
// Streaming 3x3 binomial blur. Pixels of one frame enter in raster order on the slave
// stream, one transfer per ready clock; the frame size comes from the image_width and
// image_height registers, clamped to [2, MAX_WIDTH] and [2, MAX_HEIGHT]. A [1 2 1]
// pass runs across each row and then down each column, with the edge pixel
// replicated at every border, and each result is exactly sixteen times the blurred
// value, with no rounding. The result for row r-1 leaves while row r streams in; on
// the last row every pixel yields two results, the pixel above and then itself.
// Each result carries its column and row, tlast marks the final result caused by
// one input pixel and tuser marks the final pixel of the frame. The block takes one
// pixel per clock on every row but the last, unless the result stream is held
// back; on the last row, where each pixel yields two results, the single result
// port, at one transfer a clock, holds the pixel rate lower. The row stores sit in
// one dual-port RAM that is read in the cycle before the vertical sum; they need
// no clearing after reset, as stale data read from them never reaches a result.
module binomial_blur_3x3_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int PIXEL_BITS = 16,
	localparam int WB        = $clog2(MAX_WIDTH + 1),
	localparam int HCB       = $clog2(MAX_HEIGHT + 1),
	localparam int CFG_BITS  = (WB > HCB) ? WB : HCB,
	localparam int CB        = $clog2(MAX_WIDTH),
	localparam int RWB       = $clog2(MAX_HEIGHT),
	localparam int RB        = PIXEL_BITS + 4,
	localparam int IN_BITS   = ((PIXEL_BITS + 7) / 8) * 8,
	localparam int OUT_BITS  = ((RB + CB + RWB + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bb3_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]             cfg_data,

	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [IN_BITS-1:0]              s_axis_tdata,  // pixel

	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [OUT_BITS-1:0]             m_axis_tdata,  // blurred, out_col, out_row
	output logic                            m_axis_tlast,  // last_in_run
	output logic                            m_axis_tuser   // frame_done
);

	// Horizontal sums carry two extra bits, vertical results four.
	localparam int HB        = PIXEL_BITS + 2;
	localparam int OPW       = HB + CB + RWB + 3;
	localparam int RESW      = RB + CB + RWB + 2;
	localparam int OP_DEPTH  = 4;
	localparam int OUT_DEPTH = 8;
	localparam int OPCB      = $clog2(OP_DEPTH) + 1;
	localparam int OUTCB     = $clog2(OUT_DEPTH) + 1;

	// One pending vertical operation: a horizontal sum at column x of a row.
	typedef struct packed {
		logic                 ends_run;
		logic                 done;
		logic                 last_row;
		logic [RWB-1:0]       row;
		logic [CB-1:0]        x;
		logic signed [HB-1:0] hsum;
	} op_t;

	typedef struct packed {
		logic                 done;
		logic                 last;
		logic [RWB-1:0]       row;
		logic [CB-1:0]        col;
		logic signed [RB-1:0] value;
	} res_t;

	// Configuration registers. Writes are accepted in every cycle.
	logic [WB-1:0]  width_q;
	logic [HCB-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WB'(MAX_WIDTH);
			height_q <= HCB'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bb3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[WB-1:0];
				bb3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[HCB-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size after clamping.
	logic [WB-1:0]  w_eff;
	logic [HCB-1:0] h_eff;

	always_comb begin
		priority if (width_q < WB'(2)) begin
			w_eff = WB'(2);
		end else if (width_q > WB'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		priority if (height_q < HCB'(2)) begin
			h_eff = HCB'(2);
		end else if (height_q > HCB'(MAX_HEIGHT)) begin
			h_eff = HCB'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Input side: position counters, the two previous pixels of the row, and the
	// horizontal sums. A pixel at column c finishes the sum of column c-1, and the
	// last pixel of a row also finishes its own sum, so one transfer queues zero,
	// one or two vertical operations.
	logic [CB-1:0]                col_q;
	logic [RWB-1:0]               row_q;
	logic signed [PIXEL_BITS-1:0] prev_q;
	logic signed [PIXEL_BITS-1:0] pprev_q;

	logic                         in_acc;
	logic                         last_col;
	logic                         last_row;
	logic signed [PIXEL_BITS-1:0] pix;
	logic signed [HB-1:0]         pix_x;
	logic signed [HB-1:0]         prev_x;
	logic signed [HB-1:0]         pprev_x;
	op_t                          op_mid;
	op_t                          op_end;

	logic [OPCB-1:0]              op_count;
	op_t                          op_head;
	bb3_pkg::fifo_ctl_t           op_ctl;

	// Two free slots are always kept for the worst case of one pixel.
	assign s_axis_tready = op_count <= OPCB'(OP_DEPTH - 2);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign pix      = $signed(s_axis_tdata[PIXEL_BITS-1:0]);
	assign pix_x    = HB'(pix);
	assign prev_x   = HB'(prev_q);
	assign pprev_x  = HB'(pprev_q);
	assign last_col = WB'(col_q) >= (w_eff - WB'(1));
	assign last_row = HCB'(row_q) >= (h_eff - HCB'(1));

	always_comb begin
		op_mid.ends_run = !last_col;
		op_mid.done     = 1'b0;
		op_mid.last_row = last_row;
		op_mid.row      = row_q;
		op_mid.x        = col_q - CB'(1);
		if (col_q == CB'(1)) begin
			op_mid.hsum = prev_x + (prev_x <<< 1) + pix_x;
		end else begin
			op_mid.hsum = pprev_x + (prev_x <<< 1) + pix_x;
		end

		op_end.ends_run = 1'b1;
		op_end.done     = last_row;
		op_end.last_row = last_row;
		op_end.row      = row_q;
		op_end.x        = col_q;
		op_end.hsum     = pix_x + (pix_x <<< 1) + prev_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prev_q  <= '0;
			pprev_q <= '0;
		end else if (in_acc) begin
			pprev_q <= prev_q;
			prev_q  <= pix;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RWB'(1);
			end else begin
				col_q <= col_q + CB'(1);
			end
		end
	end

	// Column zero has no finished sum yet; the last column always has column
	// c-1 before it, so the second slot only follows the first.
	logic op_two;

	assign op_two = in_acc && last_col;

	bb3_fifo2 #(
		.WIDTH (OPW),
		.DEPTH (OP_DEPTH)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (op_ctl),
		.din0   (op_two && col_q == '0 ? op_end : op_mid),
		.din1   (op_end),
		.dout   (op_head),
		.count  (op_count)
	);

	// Vertical side. An operation is issued only when the result queue can take
	// two results for it and two for the one already in flight, so the stage
	// never has to stall once it holds an operation.
	logic [OUTCB-1:0] out_count;
	logic             issue;
	logic             v1_valid_q;
	op_t              op_s1;
	logic [2*HB-1:0]  store_rd;

	assign issue = (op_count != '0) &&
		((out_count <= OUTCB'(OUT_DEPTH - 4)) ||
		(!v1_valid_q && out_count <= OUTCB'(OUT_DEPTH - 2)));

	assign op_ctl.push0 = in_acc && (col_q != '0 || last_col);
	assign op_ctl.push1 = op_two && col_q != '0;
	assign op_ctl.pop   = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_valid_q <= 1'b0;
		end else begin
			v1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1 <= op_head;
		end
	end

	// Each entry holds the sums of the two rows above: older in the upper half,
	// newer in the lower half. The entry read for an operation is rewritten the
	// next cycle, and the following operation is always at another column.
	logic signed [HB-1:0] above;
	logic signed [HB-1:0] older;

	assign above = $signed(store_rd[HB-1:0]);
	assign older = $signed(store_rd[2*HB-1:HB]);

	bb3_ram #(
		.WIDTH (2 * HB),
		.DEPTH (MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (v1_valid_q),
		.waddr (op_s1.x),
		.wdata ({above, op_s1.hsum}),
		.re    (issue),
		.raddr (op_head.x),
		.rdata (store_rd)
	);

	logic signed [RB-1:0] above_x;
	logic signed [RB-1:0] older_x;
	logic signed [RB-1:0] hsum_x;
	logic                 has_up;
	res_t                 res_up;
	res_t                 res_self;
	bb3_pkg::fifo_ctl_t   out_ctl;
	res_t                 out_head;

	assign above_x = RB'(above);
	assign older_x = RB'(older);
	assign hsum_x  = RB'(op_s1.hsum);
	assign has_up  = op_s1.row != '0;

	always_comb begin
		res_up.done  = 1'b0;
		res_up.last  = op_s1.ends_run && !op_s1.last_row;
		res_up.row   = op_s1.row - RWB'(1);
		res_up.col   = op_s1.x;
		if (op_s1.row == RWB'(1)) begin
			// Top border: the row above is replicated.
			res_up.value = above_x + (above_x <<< 1) + hsum_x;
		end else begin
			res_up.value = older_x + (above_x <<< 1) + hsum_x;
		end

		// Bottom border: the current row is replicated.
		res_self.done  = op_s1.done;
		res_self.last  = op_s1.ends_run;
		res_self.row   = op_s1.row;
		res_self.col   = op_s1.x;
		res_self.value = hsum_x + (hsum_x <<< 1) + above_x;
	end

	assign out_ctl.push0 = v1_valid_q && has_up;
	assign out_ctl.push1 = v1_valid_q && has_up && op_s1.last_row;
	assign out_ctl.pop   = m_axis_tvalid && m_axis_tready;

	bb3_fifo2 #(
		.WIDTH (RESW),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (out_ctl),
		.din0   (res_up),
		.din1   (res_self),
		.dout   (out_head),
		.count  (out_count)
	);

	assign m_axis_tvalid = out_count != '0;
	assign m_axis_tdata  = OUT_BITS'({out_head.row, out_head.col, out_head.value});
	assign m_axis_tlast  = out_head.last;
	assign m_axis_tuser  = out_head.done;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("frame end flag on a result that does not end its run");

	a_store_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && v1_valid_q) |-> op_head.x != op_s1.x)
		else $error("row store read and write collide on one column");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_col) |=> col_q == '0)
		else $error("column counter did not wrap after the last column");

endmodule

### rtl/bb3_ram.sv
module bb3_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/bb3_fifo2.sv
module bb3_fifo2 #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bb3_pkg::fifo_ctl_t       ctl,
	input  logic [WIDTH-1:0]         din0,
	input  logic [WIDTH-1:0]         din1,
	output logic [WIDTH-1:0]         dout,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int PB = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PB-1:0]    wptr_q;
	logic [PB-1:0]    rptr_q;
	logic [PB:0]      count_q;
	logic [PB-1:0]    wptr_next;

	assign wptr_next = wptr_q + PB'(1);
	assign dout      = mem[rptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (ctl.push0) begin
			mem[wptr_q] <= din0;
		end
		if (ctl.push1) begin
			mem[wptr_next] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PB'(ctl.push0) + PB'(ctl.push1);
			if (ctl.pop) begin
				rptr_q <= rptr_q + PB'(1);
			end
			count_q <= count_q + (PB+1)'(ctl.push0) + (PB+1)'(ctl.push1)
				- (PB+1)'(ctl.pop);
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push1 |-> ctl.push0)
		else $error("second push slot used without the first");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push0 || ctl.push1) |->
			((PB+2)'(count_q) + (PB+2)'(ctl.push0) + (PB+2)'(ctl.push1)) <= (PB+2)'(DEPTH))
		else $error("queue overflow");

endmodule
